// ===== hdl/lrr_pkg.sv =====
// Shared types and constants for the LFSR random range generator.
package lrr_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = $clog2(WORD_W);

  typedef logic        [WORD_W-1:0] uword_t;
  typedef logic signed [WORD_W-1:0] sword_t;
  typedef logic        [WORD_W-2:0] span_t;
  typedef logic        [COUNT_W-1:0] count_t;

  localparam uword_t LFSR_TAPS  = 32'hB4BC_D35C;
  localparam uword_t LFSR_RESET = 32'h0000_0001;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

// ===== hdl/lfsr_random_range_core.sv =====
// Galois LFSR random number source with a bit-serial modulo into a signed range.
//
// A seed transfer loads a nonzero seed_value into the 32-bit generator (zero is
// dropped) and gives no result. A draw transfer with a positive span (high_bound
// minus low_bound, 32-bit wrapped, and low_bound below high_bound) steps the LFSR
// once and reduces the new state modulo the span in a radix-2 restoring divider
// that retires one dividend bit per cycle, so a draw holds the input side stalled
// through the accept, 32 divide steps and the final add of low_bound, which waits
// while an earlier result still waits in the output register. Any other draw
// returns low_bound. The result sits in an output register, so the next item
// is taken while a finished result still waits for its transfer.
module lfsr_random_range_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           command,
  input  lrr_pkg::sword_t low_bound,
  input  lrr_pkg::sword_t high_bound,
  input  lrr_pkg::uword_t seed_value,
  output logic           out_valid,
  input  logic           out_stall,
  output lrr_pkg::sword_t random_value
);
  import lrr_pkg::*;

  state_t state;
  state_t state_next;

  uword_t lfsr;
  uword_t lfsr_step;
  uword_t dividend;
  sword_t low_reg;
  span_t  span;
  span_t  rem;
  span_t  rem_next;
  count_t count;

  uword_t span_full;
  logic   span_ok;
  logic   in_xfer;
  logic   out_load;
  uword_t trial;
  span_t  diff;

  assign in_xfer   = in_valid && !in_stall;
  assign span_full = uword_t'(high_bound - low_bound);
  assign span_ok   = (low_bound < high_bound) && (span_full != '0) && !span_full[WORD_W-1];
  assign lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);

  assign trial    = {rem, dividend[WORD_W-1]};
  assign diff     = trial[WORD_W-2:0] - span;
  assign rem_next = (trial >= {1'b0, span}) ? diff : trial[WORD_W-2:0];

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && command == CMD_DRAW) begin
          state_next = span_ok ? ST_DIVIDE : ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        if (count == count_t'(WORD_W - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr      <= LFSR_RESET;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (command == CMD_SEED) begin
          if (seed_value != '0) begin
            lfsr <= seed_value;
          end
        end else if (span_ok) begin
          lfsr <= lfsr_step;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && command == CMD_DRAW) begin
      low_reg  <= low_bound;
      span     <= span_full[WORD_W-2:0];
      dividend <= lfsr_step;
      rem      <= '0;
      count    <= '0;
    end else if (state == ST_DIVIDE) begin
      rem      <= rem_next;
      dividend <= dividend << 1;
      count    <= count + count_t'(1);
    end
    if (out_load) begin
      random_value <= sword_t'(uword_t'(low_reg) + {1'b0, rem});
    end
  end

endmodule
